[hw/rtl/hmed_pkg.sv]
// types and constants shared by the http message end detector
// no dependencies
`timescale 1ns / 1ps

package hmed_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int CHUNK_BITS  = 32;
    localparam int REM_BITS    = (LENGTH_BITS > CHUNK_BITS) ? LENGTH_BITS : CHUNK_BITS;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    localparam logic [8*17-1:0] TE_NAME    = "transfer-encoding";
    localparam logic [8*14-1:0] CL_NAME    = "content-length";
    localparam logic [8*7-1:0]  CHUNK_WORD = "chunked";

    typedef enum logic [3:0] {
        PH_REQ, PH_NAME, PH_SKIP, PH_TE, PH_CL,
        PH_BODY, PH_CSIZE, PH_CDATA, PH_TRAIL1, PH_TRAIL2
    } t_phase;

    typedef enum logic [2:0] {
        END_NONE, END_NO_BODY, END_LENGTH, END_LAST_CHUNK, END_BAD_LENGTH, END_BAD_CHUNK
    } t_ending;

    typedef struct packed {
        t_phase                 phase;
        logic [1:0]             term;
        logic [4:0]             npos;
        logic [1:0]             cand;
        logic                   ntrail;
        logic [1:0]             found;
        logic [4:0]             tok;
        logic [LENGTH_BITS-1:0] len;
        logic [2:0]             lfl;
        logic [CHUNK_BITS-1:0]  csz;
        logic [3:0]             sfl;
        logic [REM_BITS-1:0]    rem;
        logic                   pcr;
    } t_state;

    typedef struct packed {
        logic    done;
        t_ending ending;
        logic    is_body;
    } t_result;

endpackage

[hw/rtl/hmed_parse.sv]
// parser state register and the per-word next-state logic
// depends on hmed_pkg
`timescale 1ns / 1ps

module hmed_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    output hmed_pkg::t_result o_res
);

    hmed_pkg::t_state r_st, n_st;

    function automatic hmed_pkg::t_state reset_state();
        hmed_pkg::t_state s;
        s = '0;
        s.phase = hmed_pkg::PH_REQ;
        s.cand  = 2'b11;
        return s;
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == hmed_pkg::CH_SP || c == hmed_pkg::CH_TAB;
    endfunction

    function automatic hmed_pkg::t_state token_end(hmed_pkg::t_state s);
        hmed_pkg::t_state r;
        r = s;
        if (s.tok[2:0] == 3'd7) r.tok[4] = 1'b1;
        r.tok[3:0] = 4'd0;
        return r;
    endfunction

    function automatic hmed_pkg::t_state line_char(hmed_pkg::t_state s, logic [7:0] c);
        hmed_pkg::t_state r;
        logic [7:0] lc, te_ch, cl_ch, ck_ch;
        logic [2:0] p;
        logic [hmed_pkg::LENGTH_BITS+3:0] prod;
        r = s;
        lc = lower(c);
        te_ch = (s.npos < 5'd17) ? hmed_pkg::TE_NAME[8*(16-s.npos) +: 8] : 8'h00;
        cl_ch = (s.npos < 5'd14) ? hmed_pkg::CL_NAME[8*(13-s.npos) +: 8] : 8'h00;
        p = s.tok[2:0];
        ck_ch = (p < 3'd7) ? hmed_pkg::CHUNK_WORD[8*(6-p) +: 8] : 8'h00;
        prod = {4'd0, s.len} * (hmed_pkg::LENGTH_BITS+4)'(10)
             + (hmed_pkg::LENGTH_BITS+4)'(c - "0");
        case (s.phase)
            hmed_pkg::PH_NAME: begin
                if (c == hmed_pkg::CH_COLON) begin
                    if (s.cand[0] && s.npos == 5'd17 && !s.found[0]) begin
                        r.found[0] = 1'b1;
                        r.phase = hmed_pkg::PH_TE;
                    end else if (s.cand[1] && s.npos == 5'd14 && !s.found[1]) begin
                        r.found[1] = 1'b1;
                        r.phase = hmed_pkg::PH_CL;
                    end else begin
                        r.phase = hmed_pkg::PH_SKIP;
                    end
                end else if (blank(c)) begin
                    if (s.npos != 5'd0) r.ntrail = 1'b1;
                end else begin
                    if (s.ntrail) r.cand = 2'b00;
                    if (s.npos >= 5'd17 || te_ch != lc) r.cand[0] = 1'b0;
                    if (s.npos >= 5'd14 || cl_ch != lc) r.cand[1] = 1'b0;
                    if (s.npos != 5'd31) r.npos = s.npos + 5'd1;
                end
            end
            hmed_pkg::PH_TE: begin
                if (c == hmed_pkg::CH_COMMA) begin
                    r = token_end(s);
                end else if (blank(c)) begin
                    if (p != 3'd0 || s.tok[3]) r.tok[3] = 1'b1;
                end else if (s.tok[3] || p == 3'd7 || ck_ch != lc) begin
                    r.tok = {s.tok[4], 1'b1, 3'd0};
                end else begin
                    r.tok = {s.tok[4], 1'b0, p + 3'd1};
                end
            end
            hmed_pkg::PH_CL: begin
                if (blank(c)) begin
                    if (s.lfl[0]) r.lfl[1] = 1'b1;
                end else if (c >= "0" && c <= "9") begin
                    if (s.lfl[1] || s.lfl[2]) r.lfl[2] = 1'b1;
                    else if (prod[hmed_pkg::LENGTH_BITS+3:hmed_pkg::LENGTH_BITS] != 4'd0)
                        r.lfl[2] = 1'b1;
                    else r.len = prod[hmed_pkg::LENGTH_BITS-1:0];
                    r.lfl[0] = 1'b1;
                end else begin
                    r.lfl[2] = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic hmed_pkg::t_state size_char(hmed_pkg::t_state s, logic [7:0] c);
        hmed_pkg::t_state r;
        logic       hv;
        logic [3:0] h;
        r = s;
        hv = 1'b1;
        h = 4'd0;
        if (c >= "0" && c <= "9") h = 4'(c - "0");
        else if (c >= "a" && c <= "f") h = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") h = 4'(c - "A" + 8'd10);
        else hv = 1'b0;
        if (!s.sfl[3]) begin
            if (c == hmed_pkg::CH_SEMI) begin
                r.sfl[3] = 1'b1;
            end else if (blank(c)) begin
                if (s.sfl[0]) r.sfl[1] = 1'b1;
            end else if (!hv) begin
                r.sfl[2] = 1'b1;
            end else begin
                if (s.sfl[1] || s.sfl[2]
                    || s.csz[hmed_pkg::CHUNK_BITS-1:hmed_pkg::CHUNK_BITS-4] != 4'd0)
                    r.sfl[2] = 1'b1;
                else r.csz = {s.csz[hmed_pkg::CHUNK_BITS-5:0], h};
                r.sfl[0] = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb begin
        hmed_pkg::t_state s;
        hmed_pkg::t_ending e;
        logic body, handled;
        s = r_st;
        e = hmed_pkg::END_NONE;
        body = 1'b0;
        handled = 1'b0;
        if (s.phase inside {hmed_pkg::PH_REQ, hmed_pkg::PH_NAME, hmed_pkg::PH_SKIP,
                            hmed_pkg::PH_TE, hmed_pkg::PH_CL}) begin
            if (i_byte == hmed_pkg::CH_CR) begin
                s.term = (s.term == 2'd2) ? 2'd3 : 2'd1;
            end else if (i_byte == hmed_pkg::CH_LF) begin
                if (s.term == 2'd3) begin
                    handled = 1'b1;
                    s.pcr = 1'b0;
                    s.term = 2'd0;
                    if (s.tok[4]) begin
                        s.phase = hmed_pkg::PH_CSIZE;
                        s.csz = '0;
                        s.sfl = '0;
                    end else if (s.lfl[0] || s.lfl[2]) begin
                        if (s.lfl[2]) e = hmed_pkg::END_BAD_LENGTH;
                        else if (s.len == '0) e = hmed_pkg::END_LENGTH;
                        else begin
                            s.rem = hmed_pkg::REM_BITS'(s.len);
                            s.phase = hmed_pkg::PH_BODY;
                        end
                    end else begin
                        e = hmed_pkg::END_NO_BODY;
                    end
                end else begin
                    s.term = (s.term == 2'd1) ? 2'd2 : 2'd0;
                end
            end else begin
                s.term = 2'd0;
            end
            if (!handled && s.pcr) begin
                s.pcr = 1'b0;
                if (i_byte == hmed_pkg::CH_LF) begin
                    handled = 1'b1;
                    if (s.phase == hmed_pkg::PH_TE) s = token_end(s);
                    s.phase = hmed_pkg::PH_NAME;
                    s.npos = 5'd0;
                    s.cand = 2'b11;
                    s.ntrail = 1'b0;
                end else begin
                    s = line_char(s, hmed_pkg::CH_CR);
                end
            end
            if (!handled) begin
                if (i_byte == hmed_pkg::CH_CR) s.pcr = 1'b1;
                else s = line_char(s, i_byte);
            end
        end else begin
            body = 1'b1;
            case (s.phase)
                hmed_pkg::PH_BODY: begin
                    if (s.rem != '0) s.rem = s.rem - 1'b1;
                    if (s.rem == '0) e = hmed_pkg::END_LENGTH;
                end
                hmed_pkg::PH_CSIZE: begin
                    if (s.pcr) begin
                        s.pcr = 1'b0;
                        if (i_byte == hmed_pkg::CH_LF) begin
                            handled = 1'b1;
                            if (s.sfl[2] || !s.sfl[0]) e = hmed_pkg::END_BAD_CHUNK;
                            else if (s.csz == '0) e = hmed_pkg::END_LAST_CHUNK;
                            else begin
                                s.rem = hmed_pkg::REM_BITS'(s.csz);
                                s.csz = '0;
                                s.sfl = '0;
                                s.phase = hmed_pkg::PH_CDATA;
                            end
                        end else begin
                            s = size_char(s, hmed_pkg::CH_CR);
                        end
                    end
                    if (!handled) begin
                        if (i_byte == hmed_pkg::CH_CR) s.pcr = 1'b1;
                        else s = size_char(s, i_byte);
                    end
                end
                hmed_pkg::PH_CDATA: begin
                    if (s.rem != '0) s.rem = s.rem - 1'b1;
                    if (s.rem == '0) s.phase = hmed_pkg::PH_TRAIL1;
                end
                hmed_pkg::PH_TRAIL1: begin
                    s.pcr = (i_byte == hmed_pkg::CH_CR);
                    s.phase = hmed_pkg::PH_TRAIL2;
                end
                default: begin
                    // chunk data must close with cr lf
                    if (s.pcr && i_byte == hmed_pkg::CH_LF) begin
                        s.pcr = 1'b0;
                        s.csz = '0;
                        s.sfl = '0;
                        s.phase = hmed_pkg::PH_CSIZE;
                    end else begin
                        e = hmed_pkg::END_BAD_CHUNK;
                    end
                end
            endcase
        end
        if (e != hmed_pkg::END_NONE) s = reset_state();
        n_st = s;
        o_res.done = (e != hmed_pkg::END_NONE);
        o_res.ending = e;
        o_res.is_body = body;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= reset_state();
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

endmodule

[hw/rtl/http_message_end_detector.sv]
// top level of the http message end detector: input word register,
// parser, result register; depends on hmed_pkg and hmed_parse
`timescale 1ns / 1ps

// usage:
//   input channel i_valid / o_stall carries one request byte per word
//   (i_data_byte); output channel o_valid / i_stall carries one result word
//   per input byte: o_done_res, o_ending, o_is_body.
//   a byte is taken when i_valid is high and o_stall is low; a result is
//   taken when o_valid is high and i_stall is low.
//   the byte lands in an input register; when it advances, the parser
//   updates its state and loads the result register.
//   throughput is one byte per clock while i_stall is low; the per-byte
//   state update is a single combinational pass between the two registers.
//   when the receiver stalls, the result register holds and the input
//   register keeps at most one further byte; o_stall rises only when both
//   are full.
//   after a completing byte the parser returns to its reset state and the
//   next byte starts a new request.
//   synchronous reset empties both registers and puts the parser in the
//   request line state.
module http_message_end_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_done_res,
    output logic [2:0] o_ending,
    output logic       o_is_body
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    hmed_pkg::t_result r_out;
    hmed_pkg::t_result res;
    logic              out_take, s1_adv, in_take;

    assign out_take = !r_out_valid || !i_stall;
    assign s1_adv   = r_in_valid && out_take;
    assign in_take  = !r_in_valid || s1_adv;
    assign o_stall  = !in_take;

    hmed_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_adv),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) r_in_valid <= i_valid;
            if (out_take) r_out_valid <= s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) r_in_byte <= i_data_byte;
        if (s1_adv) r_out <= res;
    end

    assign o_valid    = r_out_valid;
    assign o_done_res = r_out.done;
    assign o_ending   = r_out.ending;
    assign o_is_body  = r_out.is_body;

endmodule

[tb/tb_http_message_end_detector.sv]
// testbench for the http message end detector: byte driver, result monitor,
// scoreboard fed by a behavioral parser model; depends on hmed_pkg and the rtl
`timescale 1ns / 1ps

module tb_http_message_end_detector;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall, o_valid, o_done_res, o_is_body;
    logic [2:0] o_ending;

    http_message_end_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_done_res(o_done_res), .o_ending(o_ending), .o_is_body(o_is_body)
    );

    always #2 i_clk = ~i_clk;

    // parser model state
    hmed_pkg::t_phase                 m_phase;
    logic [1:0]                       m_term;
    int unsigned                      m_npos;
    logic [1:0]                       m_cand;
    logic                             m_ntrail;
    logic [1:0]                       m_found;
    logic [4:0]                       m_tok;
    logic [hmed_pkg::LENGTH_BITS-1:0] m_len;
    logic [2:0]                       m_lfl;
    logic [hmed_pkg::CHUNK_BITS-1:0]  m_csz;
    logic [3:0]                       m_sfl;
    logic [63:0]                      m_rem;
    logic                             m_pcr;

    logic [7:0]        byte_q[$];
    hmed_pkg::t_result result_q[$];
    int                n_fail = 0;
    int                n_results = 0;
    int                n_done = 0;
    int                idle_cycles = 0;
    bit                stim_done = 1'b0;
    bit                hold_off = 1'b0;

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == hmed_pkg::CH_SP || c == hmed_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] str_at(string s, int unsigned i);
        return s[i];
    endfunction

    function automatic void parser_clear();
        m_phase = hmed_pkg::PH_REQ; m_term = 0; m_npos = 0; m_cand = 2'b11; m_ntrail = 0;
        m_found = 0; m_tok = 0; m_len = 0; m_lfl = 0; m_csz = 0; m_sfl = 0;
        m_rem = 0; m_pcr = 0;
    endfunction

    function automatic void token_close();
        if (m_tok[2:0] == 3'd7) m_tok[4] = 1'b1;
        m_tok = m_tok & 5'h10;
    endfunction

    function automatic void header_char(logic [7:0] c);
        logic [2:0] p;
        logic [3:0] d;
        if (m_phase == hmed_pkg::PH_NAME) begin
            if (c == hmed_pkg::CH_COLON) begin
                if (m_cand[0] && m_npos == 17 && !m_found[0]) begin
                    m_found[0] = 1; m_phase = hmed_pkg::PH_TE;
                end else if (m_cand[1] && m_npos == 14 && !m_found[1]) begin
                    m_found[1] = 1; m_phase = hmed_pkg::PH_CL;
                end else begin
                    m_phase = hmed_pkg::PH_SKIP;
                end
            end else if (blank(c)) begin
                if (m_npos > 0) m_ntrail = 1;
            end else begin
                c = lc(c);
                if (m_ntrail) m_cand = 0;
                if (m_npos >= 17 || str_at("transfer-encoding", m_npos) != c) m_cand[0] = 0;
                if (m_npos >= 14 || str_at("content-length", m_npos) != c) m_cand[1] = 0;
                if (m_npos < 31) m_npos++;
            end
        end else if (m_phase == hmed_pkg::PH_TE) begin
            p = m_tok[2:0];
            if (c == hmed_pkg::CH_COMMA) token_close();
            else if (blank(c)) begin
                if (p > 0 || m_tok[3]) m_tok[3] = 1;
            end else if (m_tok[3] || p >= 7 || str_at("chunked", p) != lc(c))
                m_tok = (m_tok & 5'h10) | 5'h08;
            else
                m_tok = (m_tok & 5'h10) | (p + 1);
        end else if (m_phase == hmed_pkg::PH_CL) begin
            if (blank(c)) begin
                if (m_lfl[0]) m_lfl[1] = 1;
            end else if (c >= "0" && c <= "9") begin
                d = c - "0";
                if (m_lfl[2:1] != 0) m_lfl[2] = 1;
                else if ({32'd0, m_len} * 10 + d > {32'd0, {hmed_pkg::LENGTH_BITS{1'b1}}})
                    m_lfl[2] = 1;
                else m_len = m_len * 10 + d;
                m_lfl[0] = 1;
            end else begin
                m_lfl[2] = 1;
            end
        end
    endfunction

    function automatic void size_char(logic [7:0] c);
        int h;
        if (m_sfl[3]) return;
        if (c == hmed_pkg::CH_SEMI) begin m_sfl[3] = 1; return; end
        if (blank(c)) begin
            if (m_sfl[0]) m_sfl[1] = 1;
            return;
        end
        if (c >= "0" && c <= "9") h = c - "0";
        else if (c >= "a" && c <= "f") h = c - "a" + 10;
        else if (c >= "A" && c <= "F") h = c - "A" + 10;
        else h = -1;
        if (h < 0) begin m_sfl[2] = 1; return; end
        if (m_sfl[2:1] != 0 || m_csz[hmed_pkg::CHUNK_BITS-1 -: 4] != 0) m_sfl[2] = 1;
        else m_csz = {m_csz[hmed_pkg::CHUNK_BITS-5:0], h[3:0]};
        m_sfl[0] = 1;
    endfunction

    // returns the ending code for one byte
    function automatic hmed_pkg::t_ending parse_byte(logic [7:0] b);
        if (m_phase <= hmed_pkg::PH_CL) begin
            if (b == hmed_pkg::CH_CR) m_term = (m_term == 2) ? 2'd3 : 2'd1;
            else if (b == hmed_pkg::CH_LF) begin
                if (m_term == 3) begin
                    m_pcr = 0; m_term = 0;
                    if (m_tok[4]) begin
                        m_phase = hmed_pkg::PH_CSIZE; m_csz = 0; m_sfl = 0;
                        return hmed_pkg::END_NONE;
                    end
                    if (m_lfl[0] || m_lfl[2]) begin
                        if (m_lfl[2]) return hmed_pkg::END_BAD_LENGTH;
                        if (m_len == 0) return hmed_pkg::END_LENGTH;
                        m_rem = m_len; m_phase = hmed_pkg::PH_BODY;
                        return hmed_pkg::END_NONE;
                    end
                    return hmed_pkg::END_NO_BODY;
                end
                m_term = (m_term == 1) ? 2'd2 : 2'd0;
            end else m_term = 0;
            if (m_pcr) begin
                m_pcr = 0;
                if (b == hmed_pkg::CH_LF) begin
                    if (m_phase == hmed_pkg::PH_TE) token_close();
                    m_phase = hmed_pkg::PH_NAME; m_npos = 0; m_cand = 2'b11; m_ntrail = 0;
                    return hmed_pkg::END_NONE;
                end
                header_char(hmed_pkg::CH_CR);
            end
            if (b == hmed_pkg::CH_CR) m_pcr = 1;
            else header_char(b);
            return hmed_pkg::END_NONE;
        end
        case (m_phase)
            hmed_pkg::PH_BODY: begin
                if (m_rem > 0) m_rem--;
                return m_rem == 0 ? hmed_pkg::END_LENGTH : hmed_pkg::END_NONE;
            end
            hmed_pkg::PH_CSIZE: begin
                if (m_pcr) begin
                    m_pcr = 0;
                    if (b == hmed_pkg::CH_LF) begin
                        if (m_sfl[2] || !m_sfl[0]) return hmed_pkg::END_BAD_CHUNK;
                        if (m_csz == 0) return hmed_pkg::END_LAST_CHUNK;
                        m_rem = m_csz; m_csz = 0; m_sfl = 0; m_phase = hmed_pkg::PH_CDATA;
                        return hmed_pkg::END_NONE;
                    end
                    size_char(hmed_pkg::CH_CR);
                end
                if (b == hmed_pkg::CH_CR) m_pcr = 1;
                else size_char(b);
                return hmed_pkg::END_NONE;
            end
            hmed_pkg::PH_CDATA: begin
                if (m_rem > 0) m_rem--;
                if (m_rem == 0) m_phase = hmed_pkg::PH_TRAIL1;
                return hmed_pkg::END_NONE;
            end
            hmed_pkg::PH_TRAIL1: begin
                m_pcr = (b == hmed_pkg::CH_CR);
                m_phase = hmed_pkg::PH_TRAIL2;
                return hmed_pkg::END_NONE;
            end
            default: begin
                if (m_pcr && b == hmed_pkg::CH_LF) begin
                    m_pcr = 0; m_csz = 0; m_sfl = 0; m_phase = hmed_pkg::PH_CSIZE;
                    return hmed_pkg::END_NONE;
                end
                return hmed_pkg::END_BAD_CHUNK;
            end
        endcase
    endfunction

    function automatic hmed_pkg::t_result predict_result(logic [7:0] b);
        hmed_pkg::t_result r;
        r.is_body = (m_phase > hmed_pkg::PH_CL);
        r.ending = parse_byte(b);
        r.done = (r.ending != hmed_pkg::END_NONE);
        if (r.done) parser_clear();
        return r;
    endfunction

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) byte_q = {byte_q, s[i]};
    endtask

    function automatic string rand_case(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if ($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z") t[i] = t[i] - 8'd32;
        return t;
    endfunction

    function automatic string blanks();
        string t;
        t = "";
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) t = {t, " "};
            else t = {t, "\t"};
        end
        return t;
    endfunction

    function automatic string rand_text(int n);
        string t;
        t = "";
        repeat (n) begin
            logic [7:0] c;
            c = $urandom_range(32, 126);
            if (c == ":") c = "x";
            t = {t, string'(c)};
        end
        return t;
    endfunction

    // one request, mostly well formed with random content
    task automatic push_request();
        int kind, n, sz;
        string hdr, s;
        kind = $urandom_range(0, 9);
        hdr = {"GET /", rand_text($urandom_range(0, 4)), " HTTP/1.1\r\n"};
        if ($urandom_range(0, 2) == 0) hdr = {hdr, "Host: ", rand_text(3), "\r\n"};
        if (kind <= 3) begin
            n = $urandom_range(1, 3);
            hdr = {hdr, blanks(), rand_case("transfer-encoding"), blanks(), ":", blanks()};
            if ($urandom_range(0, 1)) hdr = {hdr, "gzip, "};
            hdr = {hdr, rand_case("chunked"), blanks(), "\r\n\r\n"};
            push_str(hdr);
            repeat (n) begin
                sz = $urandom_range(1, 6);
                s = $sformatf("%0h", sz);
                if ($urandom_range(0, 3) == 0) s = {s, ";x=1"};
                s = {s, "\r\n", rand_text(sz)};
                if ($urandom_range(0, 15) == 0) s = {s, "zz"};
                else s = {s, "\r\n"};
                push_str(s);
            end
            if ($urandom_range(0, 7) == 0) push_str("g\r\n");
            else push_str("0\r\n");
        end else if (kind <= 6) begin
            n = $urandom_range(0, 5);
            if ($urandom_range(0, 7) == 0) s = "1 2";
            else s = $sformatf("%0d", n);
            push_str({hdr, rand_case("content-length"), ":", blanks(), s, blanks(),
                      "\r\n\r\n", rand_text(n)});
        end else if (kind == 7) begin
            push_str({hdr, "\r\n"});
        end else begin
            repeat ($urandom_range(5, 30)) byte_q = {byte_q, 8'($urandom_range(0, 255))};
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 1)) byte_q = {byte_q, hmed_pkg::CH_CR};
                else byte_q = {byte_q, hmed_pkg::CH_LF};
            end
        end
    endtask

    initial begin
        parser_clear();
        // directed: no body, length, chunked, errors, bare cr, extremes
        push_str("GET / HTTP/1.1\r\nX\rY: 1\r\nNoColon\r\n\r\n");
        push_str("P\r\nContent-Length: 0\r\n\r\n");
        push_str("P\r\n content-LENGTH \t: \t2 \r\nContent-Length: 9\r\n\r\nab");
        push_str("P\r\nContent-Length: 0000000002\r\n\r\n");
        byte_q = {byte_q, 8'hff};
        byte_q = {byte_q, 8'h00};
        push_str("P\r\nContent-Length: 4294967296\r\n\r\n");
        push_str("P\r\nContent-Length:\r\n\r\n");
        push_str("P\r\nContent-Length: 1a\r\n\r\n");
        push_str("P\r\nTransfer-Encoding: gzip , chunked\r\n\r\n");
        push_str("3;ext\r\nabc\r\n0\r\n");
        push_str("P\r\nTransfer-Encoding: chunked\r\n\r\n100000000\r\n");
        push_str("P\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nxyzz");
        push_str("P\r\nTransfer-Encoding: chunk ed\r\nTransfer-Encoding: chunked\r\n\r\n");
        push_str("P\r\nTransfer-Encoding: chunked\r\n\r\n\r\n");
        push_str("P\r\nTransfer-Encoding: chunked\r\n\r\n1 1\r\n");
        push_str("P\r\nTransfer-Encoding: chunked\r\n\r\n0\r\n");
        while (byte_q.size() < 1850) push_request();
    end

    // driver: bursts with random gaps
    int burst = 0, gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) result_q = {result_q, predict_result(i_data_byte)};
            if (byte_q.size() == 0) begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (gap > 0) begin
                gap <= gap - 1;
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_data_byte <= byte_q.pop_front();
                if (burst == 0) begin
                    burst <= $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap <= $urandom_range(1, 5);
                end else begin
                    burst <= burst - 1;
                end
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    int cyc = 0, hold_cnt = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == 400) hold_off <= 1'b1;
        if (hold_off) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 200) hold_off <= 1'b0;
        end
        if (hold_off || (cyc == 400)) i_stall <= 1'b1;
        else if ((cyc / 500) % 3 == 2) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            hmed_pkg::t_result r;
            if (result_q.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                r = result_q.pop_front();
                n_results++;
                if (r.done) n_done++;
                if (o_done_res !== r.done) begin
                    $error("done_res expected %0d actual %0d", r.done, o_done_res);
                    n_fail++;
                end
                if (o_ending !== r.ending) begin
                    $error("ending expected %0d actual %0d", r.ending, o_ending);
                    n_fail++;
                end
                if (o_is_body !== r.is_body) begin
                    $error("is_body expected %0d actual %0d", r.is_body, o_is_body);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("[http_message_end_detector] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        wait (result_q.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("checked %0d result words, %0d completed requests, incl. long stall",
                 n_results, n_done);
        if (n_fail == 0 && result_q.size() == 0)
            $display("[http_message_end_detector] OK");
        else
            $display("[http_message_end_detector] ERROR");
        $finish;
    end
endmodule
